>>> hw/rtl/ckm_pkg.sv
// Shared types, constants and helper functions of the cascaded Kalman motion filter.
// Holds the microcode program of the sequencer. Depends on nothing else.
`timescale 1ns / 1ps

package ckm_pkg;

   // Field and datapath widths.
   localparam int EST_W     = 24;              // signed Q8.16 estimates
   localparam int COV_W     = 24;              // unsigned Q12.12 covariances
   localparam int NOISE_W   = 16;              // unsigned Q4.12 noise registers
   localparam int DEN_W     = COV_W + 1;       // gain denominator
   localparam int K_W       = 17;              // gain, unsigned Q1.16 up to 1.0
   localparam int REM_W     = DEN_W + 1;       // divider partial remainder
   localparam int MUL_B_W   = EST_W + 2;       // signed multiplier operand
   localparam int PROD_W    = K_W + 1 + MUL_B_W;
   localparam int FRAC_W    = 16;
   localparam int RND_W     = PROD_W - FRAC_W; // product after rounding shift
   localparam int SUM_W     = RND_W + 1;       // estimate before saturation
   localparam int NAXES     = 3;
   localparam int NSTAGES   = 3;
   localparam int PC_W      = 5;
   localparam int DIV_CNT_W = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [K_W-1:0]        K_ONE    = K_W'(65536);
   localparam logic [DIV_CNT_W-1:0]  DIV_STEPS = DIV_CNT_W'(K_W);
   localparam logic [COV_W-1:0]      COV_MAX  = '1;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
   localparam logic signed [EST_W-1:0]  EST_MAX  = {1'b0, {(EST_W-1){1'b1}}};
   localparam logic signed [EST_W-1:0]  EST_MIN  = {1'b1, {(EST_W-1){1'b0}}};

   // Stage and axis selectors used by the microcode.
   localparam logic [1:0] STG_ACC = 2'd0;
   localparam logic [1:0] STG_VEL = 2'd1;
   localparam logic [1:0] STG_POS = 2'd2;
   localparam logic [1:0] AX_X    = 2'd0;
   localparam logic [1:0] AX_Y    = 2'd1;
   localparam logic [1:0] AX_Z    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_PROC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_MEAS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_PROC = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_MEAS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_PROC = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_MEAS = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [NOISE_W-1:0] ACC_PROC_RST = 16'd4;
   localparam logic [NOISE_W-1:0] ACC_MEAS_RST = 16'd410;
   localparam logic [NOISE_W-1:0] VEL_PROC_RST = 16'd410;
   localparam logic [NOISE_W-1:0] VEL_MEAS_RST = 16'd819;
   localparam logic [NOISE_W-1:0] POS_PROC_RST = 16'd410;
   localparam logic [NOISE_W-1:0] POS_MEAS_RST = 16'd819;

   // Datapath operations of one microcode step.
   typedef enum logic [3:0] {
      OP_IDLE = 4'd0,   // wait for an input transfer
      OP_PRED = 4'd1,   // predict covariance, start the divider
      OP_DIV  = 4'd2,   // wait for the gain quotient
      OP_CMUL = 4'd3,   // (1 - k) * predicted covariance
      OP_CUPD = 4'd4,   // round and store covariance
      OP_AMUL = 4'd5,   // k * (meas - acc)
      OP_AUPD = 4'd6,   // acc += rounded product
      OP_VMUL = 4'd7,   // k * (vel + acc)
      OP_VUPD = 4'd8,   // vel = rounded product
      OP_PMUL = 4'd9,   // k * (pos + vel)
      OP_PUPD = 4'd10,  // pos = rounded product
      OP_OUT  = 4'd11   // load the result register
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;   // stage or axis
      logic       home;  // return to the first step afterwards
   } ucode_type;

   typedef struct packed {
      logic           busy;
      logic [K_W-1:0] quot;
   } div_stat_type;

   // Microcode program: an idle step, three gain stages, three axes of estimate updates, then the output step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_IDLE, sel: STG_ACC, home: 1'b0};
      case (pc)
         5'd0:  w = '{op: OP_IDLE, sel: STG_ACC, home: 1'b0};
         5'd1:  w = '{op: OP_PRED, sel: STG_ACC, home: 1'b0};
         5'd2:  w = '{op: OP_DIV,  sel: STG_ACC, home: 1'b0};
         5'd3:  w = '{op: OP_CMUL, sel: STG_ACC, home: 1'b0};
         5'd4:  w = '{op: OP_CUPD, sel: STG_ACC, home: 1'b0};
         5'd5:  w = '{op: OP_PRED, sel: STG_VEL, home: 1'b0};
         5'd6:  w = '{op: OP_DIV,  sel: STG_VEL, home: 1'b0};
         5'd7:  w = '{op: OP_CMUL, sel: STG_VEL, home: 1'b0};
         5'd8:  w = '{op: OP_CUPD, sel: STG_VEL, home: 1'b0};
         5'd9:  w = '{op: OP_PRED, sel: STG_POS, home: 1'b0};
         5'd10: w = '{op: OP_DIV,  sel: STG_POS, home: 1'b0};
         5'd11: w = '{op: OP_CMUL, sel: STG_POS, home: 1'b0};
         5'd12: w = '{op: OP_CUPD, sel: STG_POS, home: 1'b0};
         5'd13: w = '{op: OP_AMUL, sel: AX_X, home: 1'b0};
         5'd14: w = '{op: OP_AUPD, sel: AX_X, home: 1'b0};
         5'd15: w = '{op: OP_VMUL, sel: AX_X, home: 1'b0};
         5'd16: w = '{op: OP_VUPD, sel: AX_X, home: 1'b0};
         5'd17: w = '{op: OP_PMUL, sel: AX_X, home: 1'b0};
         5'd18: w = '{op: OP_PUPD, sel: AX_X, home: 1'b0};
         5'd19: w = '{op: OP_AMUL, sel: AX_Y, home: 1'b0};
         5'd20: w = '{op: OP_AUPD, sel: AX_Y, home: 1'b0};
         5'd21: w = '{op: OP_VMUL, sel: AX_Y, home: 1'b0};
         5'd22: w = '{op: OP_VUPD, sel: AX_Y, home: 1'b0};
         5'd23: w = '{op: OP_PMUL, sel: AX_Y, home: 1'b0};
         5'd24: w = '{op: OP_PUPD, sel: AX_Y, home: 1'b0};
         5'd25: w = '{op: OP_AMUL, sel: AX_Z, home: 1'b0};
         5'd26: w = '{op: OP_AUPD, sel: AX_Z, home: 1'b0};
         5'd27: w = '{op: OP_VMUL, sel: AX_Z, home: 1'b0};
         5'd28: w = '{op: OP_VUPD, sel: AX_Z, home: 1'b0};
         5'd29: w = '{op: OP_PMUL, sel: AX_Z, home: 1'b0};
         5'd30: w = '{op: OP_PUPD, sel: AX_Z, home: 1'b0};
         5'd31: w = '{op: OP_OUT,  sel: AX_X, home: 1'b1};
         default: w = '{op: OP_IDLE, sel: STG_ACC, home: 1'b1};
      endcase
      return w;
   endfunction

   // Sign extension of an estimate to the multiplier operand width.
   function automatic logic signed [MUL_B_W-1:0] sext_mul(input logic signed [EST_W-1:0] v);
      return {{(MUL_B_W-EST_W){v[EST_W-1]}}, v};
   endfunction

   // Clamp a wide signed value to the estimate range.
   function automatic logic signed [EST_W-1:0] sat_est(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:EST_W-1] == '0) || (v[SUM_W-1:EST_W-1] == '1);
      if (fits) begin
         return v[EST_W-1:0];
      end else if (v[SUM_W-1]) begin
         return EST_MIN;
      end else begin
         return EST_MAX;
      end
   endfunction

endpackage

>>> hw/rtl/ckm_if.sv
// Handshake channels of the cascaded Kalman motion filter: input, result and register write.
// Depends on ckm_pkg for the field widths.
`timescale 1ns / 1ps

interface ckm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ckm_pkg::EST_W-1:0]     meas_x;
   logic signed [ckm_pkg::EST_W-1:0]     meas_y;
   logic signed [ckm_pkg::EST_W-1:0]     meas_z;
   modport source (output valid, output meas_x, output meas_y, output meas_z, input ready);
   modport sink   (input valid, input meas_x, input meas_y, input meas_z, output ready);
endinterface

interface ckm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ckm_pkg::EST_W-1:0]     acc_est_x;
   logic signed [ckm_pkg::EST_W-1:0]     acc_est_y;
   logic signed [ckm_pkg::EST_W-1:0]     acc_est_z;
   logic signed [ckm_pkg::EST_W-1:0]     vel_est_x;
   logic signed [ckm_pkg::EST_W-1:0]     vel_est_y;
   logic signed [ckm_pkg::EST_W-1:0]     vel_est_z;
   logic signed [ckm_pkg::EST_W-1:0]     pos_est_x;
   logic signed [ckm_pkg::EST_W-1:0]     pos_est_y;
   logic signed [ckm_pkg::EST_W-1:0]     pos_est_z;
   modport source (output valid, input ready,
                   output acc_est_x, output acc_est_y, output acc_est_z,
                   output vel_est_x, output vel_est_y, output vel_est_z,
                   output pos_est_x, output pos_est_y, output pos_est_z);
   modport sink   (input valid, output ready,
                   input acc_est_x, input acc_est_y, input acc_est_z,
                   input vel_est_x, input vel_est_y, input vel_est_z,
                   input pos_est_x, input pos_est_y, input pos_est_z);
endinterface

interface ckm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ckm_pkg::CSR_IDX_W-1:0]        index;
   logic [ckm_pkg::NOISE_W-1:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ckm_div.sv
// Restoring divider that forms the Kalman gain floor(pp * 65536 / den), one bit per cycle.
// Depends on ckm_pkg for widths and the status struct.
`timescale 1ns / 1ps

module ckm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ckm_pkg::COV_W-1:0]     numer,
   input  logic [ckm_pkg::DEN_W-1:0]     denom,
   output ckm_pkg::div_stat_type         stat
);

   logic [ckm_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [ckm_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [ckm_pkg::K_W-1:0]       quot_ff, quot_in;
   logic [ckm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;

   logic                          rem_ge;
   logic [ckm_pkg::REM_W-1:0]     rem_diff;

   // One trial subtraction per cycle. The numerator's low 16 bits are zero, so the
   // remainder just shifts in a zero. After a subtraction the remainder is below den.
   always_comb begin
      rem_ge   = (rem_ff >= {1'b0, den_ff});
      rem_diff = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in  = {{(ckm_pkg::REM_W-ckm_pkg::COV_W){1'b0}}, numer};
         den_in  = denom;
         quot_in = '0;
         cnt_in  = ckm_pkg::DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rem_diff[ckm_pkg::REM_W-2:0], 1'b0};
         quot_in = {quot_ff[ckm_pkg::K_W-2:0], rem_ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != ckm_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.quot = quot_ff;

endmodule

>>> hw/rtl/cascaded_scalar_kalman_motion_top.sv
// Top level of the cascaded scalar Kalman motion filter: sequencer, datapath and registers.
// Depends on ckm_pkg, the channel interfaces in ckm_if and the divider ckm_div.
`timescale 1ns / 1ps

// Each transferred sample of three-axis, gravity-compensated acceleration runs through an
// acceleration, a velocity and a position Kalman stage per axis; one result holding all nine
// saturated estimates follows. The block works on one sample at a time: it takes a new sample
// only at the idle step of its program, once the last sample is through. The work runs as a
// 32-step microcode program on one shared multiplier and one bit-per-cycle divider: the divider
// forms each of the three gains, and the nine estimate updates take a multiply and a
// round-and-store step each. A finished result waits in its own register, and the next sample
// is taken while it waits; the output step holds while an earlier result is still waiting.
// Register writes are meant for idle periods; an unknown register index is ignored.

module cascaded_scalar_kalman_motion_top (
   input  logic      clock,
   input  logic      reset,
   ckm_csr_if.sink   csr_ch,
   ckm_req_if.sink   req_ch,
   ckm_rsp_if.source rsp_ch
);

   // Sequencer.
   logic [ckm_pkg::PC_W-1:0]                  pc_ff, pc_in;
   ckm_pkg::ucode_type                        uc;
   logic                                      step_wait;

   // Configuration registers, a process and a measurement noise register per stage.
   logic [ckm_pkg::NOISE_W-1:0]               proc_ff [ckm_pkg::NSTAGES];
   logic [ckm_pkg::NOISE_W-1:0]               proc_in [ckm_pkg::NSTAGES];
   logic [ckm_pkg::NOISE_W-1:0]               mnoise_ff [ckm_pkg::NSTAGES];
   logic [ckm_pkg::NOISE_W-1:0]               mnoise_in [ckm_pkg::NSTAGES];

   // Filter state.
   logic signed [ckm_pkg::EST_W-1:0]          acc_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          acc_in [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          vel_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          vel_in [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          pos_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          pos_in [ckm_pkg::NAXES];
   logic [ckm_pkg::COV_W-1:0]                 cov_ff [ckm_pkg::NSTAGES];
   logic [ckm_pkg::COV_W-1:0]                 cov_in [ckm_pkg::NSTAGES];

   // Working registers.
   logic signed [ckm_pkg::EST_W-1:0]          meas_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          meas_in [ckm_pkg::NAXES];
   logic [ckm_pkg::K_W-1:0]                   k_ff [ckm_pkg::NSTAGES];
   logic [ckm_pkg::K_W-1:0]                   k_in [ckm_pkg::NSTAGES];
   logic [ckm_pkg::COV_W-1:0]                 pp_ff, pp_in;
   logic                                      den_zero_ff, den_zero_in;
   logic signed [ckm_pkg::PROD_W-1:0]         prod_ff, prod_in;

   // Result register.
   logic signed [ckm_pkg::EST_W-1:0]          out_acc_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          out_acc_in [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          out_vel_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          out_vel_in [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          out_pos_ff [ckm_pkg::NAXES];
   logic signed [ckm_pkg::EST_W-1:0]          out_pos_in [ckm_pkg::NAXES];
   logic                                      rsp_valid_ff, rsp_valid_in;

   // Datapath nets.
   logic                                      req_xfer, rsp_xfer, csr_xfer;
   logic [ckm_pkg::COV_W:0]                   psum;
   logic [ckm_pkg::COV_W-1:0]                 pp_calc;
   logic [ckm_pkg::DEN_W-1:0]                 den_calc;
   logic [ckm_pkg::K_W-1:0]                   mul_a;
   logic signed [ckm_pkg::MUL_B_W-1:0]        mul_b;
   logic signed [ckm_pkg::PROD_W-1:0]         product;
   logic signed [ckm_pkg::PROD_W-1:0]         rnd_full;
   logic signed [ckm_pkg::RND_W-1:0]          rnd;
   logic signed [ckm_pkg::SUM_W-1:0]          rnd_ext;
   logic signed [ckm_pkg::SUM_W-1:0]          acc_sum;
   ckm_pkg::div_stat_type                     div_stat;

   assign uc       = ckm_pkg::ucode_rom(pc_ff);
   assign req_xfer = req_ch.valid & req_ch.ready;
   assign rsp_xfer = rsp_ch.valid & rsp_ch.ready;
   assign csr_xfer = csr_ch.valid & csr_ch.ready;

   // Nothing is taken while reset is held.
   assign req_ch.ready = !reset && (uc.op == ckm_pkg::OP_IDLE);
   assign csr_ch.ready = !reset;

   // Conditional jumps: a step repeats while its wait condition holds.
   always_comb begin
      case (uc.op)
         ckm_pkg::OP_IDLE: step_wait = !req_xfer;
         ckm_pkg::OP_DIV:  step_wait = div_stat.busy;
         ckm_pkg::OP_OUT:  step_wait = rsp_valid_ff && !rsp_ch.ready;
         default:          step_wait = 1'b0;
      endcase
      if (step_wait) begin
         pc_in = pc_ff;
      end else if (uc.home) begin
         pc_in = '0;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // Covariance prediction of the selected stage, saturated, and the gain denominator.
   always_comb begin
      psum     = {1'b0, cov_ff[uc.sel]}
               + {{(ckm_pkg::COV_W+1-ckm_pkg::NOISE_W){1'b0}}, proc_ff[uc.sel]};
      pp_calc  = psum[ckm_pkg::COV_W] ? ckm_pkg::COV_MAX : psum[ckm_pkg::COV_W-1:0];
      den_calc = {1'b0, pp_calc}
               + {{(ckm_pkg::DEN_W-ckm_pkg::NOISE_W){1'b0}}, mnoise_ff[uc.sel]};
   end

   ckm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (uc.op == ckm_pkg::OP_PRED),
      .numer (pp_calc),
      .denom (den_calc),
      .stat  (div_stat)
   );

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.op)
         ckm_pkg::OP_CMUL: begin
            mul_a = ckm_pkg::K_ONE - k_ff[uc.sel];
            mul_b = {{(ckm_pkg::MUL_B_W-ckm_pkg::COV_W){1'b0}}, pp_ff};
         end
         ckm_pkg::OP_AMUL: begin
            mul_a = k_ff[ckm_pkg::STG_ACC];
            mul_b = ckm_pkg::sext_mul(meas_ff[uc.sel]) - ckm_pkg::sext_mul(acc_ff[uc.sel]);
         end
         ckm_pkg::OP_VMUL: begin
            mul_a = k_ff[ckm_pkg::STG_VEL];
            mul_b = ckm_pkg::sext_mul(vel_ff[uc.sel]) + ckm_pkg::sext_mul(acc_ff[uc.sel]);
         end
         ckm_pkg::OP_PMUL: begin
            mul_a = k_ff[ckm_pkg::STG_POS];
            mul_b = ckm_pkg::sext_mul(pos_ff[uc.sel]) + ckm_pkg::sext_mul(vel_ff[uc.sel]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = $signed({1'b0, mul_a}) * mul_b;
   end

   // Round to nearest with ties upward: add one half, then drop the fraction.
   always_comb begin
      rnd_full = prod_ff + ckm_pkg::RND_HALF;
      rnd      = rnd_full[ckm_pkg::PROD_W-1:ckm_pkg::FRAC_W];
      rnd_ext  = {rnd[ckm_pkg::RND_W-1], rnd};
      acc_sum  = {{(ckm_pkg::SUM_W-ckm_pkg::EST_W){acc_ff[uc.sel][ckm_pkg::EST_W-1]}},
                  acc_ff[uc.sel]} + rnd_ext;
   end

   // Next values of the state, working and result registers.
   always_comb begin
      proc_in      = proc_ff;
      mnoise_in    = mnoise_ff;
      acc_in       = acc_ff;
      vel_in       = vel_ff;
      pos_in       = pos_ff;
      cov_in       = cov_ff;
      meas_in      = meas_ff;
      k_in         = k_ff;
      pp_in        = pp_ff;
      den_zero_in  = den_zero_ff;
      prod_in      = prod_ff;
      out_acc_in   = out_acc_ff;
      out_vel_in   = out_vel_ff;
      out_pos_in   = out_pos_ff;

      // Register writes.
      if (csr_xfer) begin
         case (csr_ch.index)
            ckm_pkg::CSR_ACC_PROC: proc_in[ckm_pkg::STG_ACC]   = csr_ch.data;
            ckm_pkg::CSR_ACC_MEAS: mnoise_in[ckm_pkg::STG_ACC] = csr_ch.data;
            ckm_pkg::CSR_VEL_PROC: proc_in[ckm_pkg::STG_VEL]   = csr_ch.data;
            ckm_pkg::CSR_VEL_MEAS: mnoise_in[ckm_pkg::STG_VEL] = csr_ch.data;
            ckm_pkg::CSR_POS_PROC: proc_in[ckm_pkg::STG_POS]   = csr_ch.data;
            ckm_pkg::CSR_POS_MEAS: mnoise_in[ckm_pkg::STG_POS] = csr_ch.data;
            default: ;
         endcase
      end

      // Sample capture.
      if (req_xfer) begin
         meas_in[ckm_pkg::AX_X] = req_ch.meas_x;
         meas_in[ckm_pkg::AX_Y] = req_ch.meas_y;
         meas_in[ckm_pkg::AX_Z] = req_ch.meas_z;
      end

      // Datapath operation of the current step.
      case (uc.op)
         ckm_pkg::OP_PRED: begin
            pp_in       = pp_calc;
            den_zero_in = (den_calc == '0);
         end
         ckm_pkg::OP_DIV: begin
            if (!div_stat.busy) begin
               k_in[uc.sel] = den_zero_ff ? '0 : div_stat.quot;
            end
         end
         ckm_pkg::OP_CMUL, ckm_pkg::OP_AMUL, ckm_pkg::OP_VMUL, ckm_pkg::OP_PMUL: begin
            prod_in = product;
         end
         ckm_pkg::OP_CUPD: begin
            // The updated covariance never exceeds the predicted one.
            cov_in[uc.sel] = rnd[ckm_pkg::COV_W-1:0];
         end
         ckm_pkg::OP_AUPD: acc_in[uc.sel] = ckm_pkg::sat_est(acc_sum);
         ckm_pkg::OP_VUPD: vel_in[uc.sel] = ckm_pkg::sat_est(rnd_ext);
         ckm_pkg::OP_PUPD: pos_in[uc.sel] = ckm_pkg::sat_est(rnd_ext);
         ckm_pkg::OP_OUT: begin
            if (!step_wait) begin
               out_acc_in = acc_ff;
               out_vel_in = vel_ff;
               out_pos_in = pos_ff;
            end
         end
         default: ;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_xfer)
                   || ((uc.op == ckm_pkg::OP_OUT) && !step_wait);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         proc_ff      <= '{ckm_pkg::ACC_PROC_RST, ckm_pkg::VEL_PROC_RST, ckm_pkg::POS_PROC_RST};
         mnoise_ff    <= '{ckm_pkg::ACC_MEAS_RST, ckm_pkg::VEL_MEAS_RST, ckm_pkg::POS_MEAS_RST};
         acc_ff       <= '{default: '0};
         vel_ff       <= '{default: '0};
         pos_ff       <= '{default: '0};
         cov_ff       <= '{default: '0};
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         proc_ff      <= proc_in;
         mnoise_ff    <= mnoise_in;
         acc_ff       <= acc_in;
         vel_ff       <= vel_in;
         pos_ff       <= pos_in;
         cov_ff       <= cov_in;
      end
      meas_ff     <= meas_in;
      k_ff        <= k_in;
      pp_ff       <= pp_in;
      den_zero_ff <= den_zero_in;
      prod_ff     <= prod_in;
      out_acc_ff  <= out_acc_in;
      out_vel_ff  <= out_vel_in;
      out_pos_ff  <= out_pos_in;
   end

   // Result channel.
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.acc_est_x = out_acc_ff[ckm_pkg::AX_X];
   assign rsp_ch.acc_est_y = out_acc_ff[ckm_pkg::AX_Y];
   assign rsp_ch.acc_est_z = out_acc_ff[ckm_pkg::AX_Z];
   assign rsp_ch.vel_est_x = out_vel_ff[ckm_pkg::AX_X];
   assign rsp_ch.vel_est_y = out_vel_ff[ckm_pkg::AX_Y];
   assign rsp_ch.vel_est_z = out_vel_ff[ckm_pkg::AX_Z];
   assign rsp_ch.pos_est_x = out_pos_ff[ckm_pkg::AX_X];
   assign rsp_ch.pos_est_y = out_pos_ff[ckm_pkg::AX_Y];
   assign rsp_ch.pos_est_z = out_pos_ff[ckm_pkg::AX_Z];

   // The divider is idle whenever a new gain computation starts.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      (uc.op == ckm_pkg::OP_PRED) |-> !div_stat.busy)
      else $error("Divider started while still busy.");

   // A nonzero denominator always yields a gain of at most one.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      ((uc.op == ckm_pkg::OP_DIV) && !div_stat.busy && !den_zero_ff)
         |-> (div_stat.quot <= ckm_pkg::K_ONE))
      else $error("Gain quotient above one.");

   // The rounded covariance fits its register and does not exceed the prediction.
   a_cov_shrink: assert property (@(posedge clock) disable iff (reset)
      (uc.op == ckm_pkg::OP_CUPD)
         |-> ((rnd[ckm_pkg::RND_W-1:ckm_pkg::COV_W] == '0)
              && (rnd[ckm_pkg::COV_W-1:0] <= pp_ff)))
      else $error("Covariance update above predicted covariance.");

   // An input transfer always starts the program at its first working step.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (pc_ff == ckm_pkg::PC_W'(1)))
      else $error("Sequencer did not start after an input transfer.");

   // A result appears only from the output step of the program.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(uc.op == ckm_pkg::OP_OUT))
      else $error("Result valid raised outside the output step.");

endmodule

>>> test/cascaded_scalar_kalman_motion_top_test.sv
// Self-checking testbench for the cascaded scalar Kalman motion filter top level.
// Needs ckm_pkg, the channel interfaces of ckm_if and the RTL of the block itself.
`timescale 1ns / 1ps

module cascaded_scalar_kalman_motion_top_test;
   import ckm_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 110;
   localparam int RANDOM_PHASES = 10;
   localparam int NREGS         = 6;
   localparam int PRINT_LIMIT   = 40;
   localparam longint ONE_Q16   = 65536;
   localparam longint HALF_Q16  = 32768;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [NOISE_W-1:0]   NOISE_TOP    = '1;

   typedef logic signed [EST_W-1:0] est_t;
   typedef logic [NOISE_W-1:0] noise_set [NREGS];
   typedef struct { est_t axis[NAXES]; } accel_vec;
   typedef struct {
      est_t acc[NAXES];
      est_t vel[NAXES];
      est_t pos[NAXES];
   } motion_est;

   // Tracks the filter state, predicts the estimates of every accepted sample and
   // compares each result transfer against the oldest prediction.
   class motion_checker;
      logic [NOISE_W-1:0] noise[NREGS];
      est_t               acc_state[NAXES];
      est_t               vel_state[NAXES];
      est_t               pos_state[NAXES];
      logic [COV_W-1:0]   acc_cov, vel_cov, pos_cov;
      motion_est          pending_estimates[$];
      int                 samples_taken, results_checked, mismatches;

      function new();
         noise[CSR_ACC_PROC] = ACC_PROC_RST;
         noise[CSR_ACC_MEAS] = ACC_MEAS_RST;
         noise[CSR_VEL_PROC] = VEL_PROC_RST;
         noise[CSR_VEL_MEAS] = VEL_MEAS_RST;
         noise[CSR_POS_PROC] = POS_PROC_RST;
         noise[CSR_POS_MEAS] = POS_MEAS_RST;
         foreach (acc_state[i]) begin
            acc_state[i] = '0;
            vel_state[i] = '0;
            pos_state[i] = '0;
         end
         acc_cov = '0;
         vel_cov = '0;
         pos_cov = '0;
         samples_taken = 0;
         results_checked = 0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [NOISE_W-1:0] value);
         if (idx <= CSR_POS_MEAS) noise[idx] = value;
      endfunction

      // Round to nearest with ties upward, then drop the 16 fraction bits.
      static function longint round_q16(longint v);
         return (v + HALF_Q16) >>> 16;
      endfunction

      static function est_t clamp_est(longint v);
         if (v > longint'(EST_MAX)) return EST_MAX;
         if (v < longint'(EST_MIN)) return EST_MIN;
         return est_t'(v);
      endfunction

      // Predicts one stage covariance, returns its gain and stores the corrected covariance.
      function longint gain_step(inout logic [COV_W-1:0] cov,
                                 input logic [NOISE_W-1:0] proc,
                                 input logic [NOISE_W-1:0] msr);
         longint unsigned pp, den, k, np;
         pp = cov;
         pp = pp + proc;
         if (pp > COV_MAX) pp = COV_MAX;
         den = pp + msr;
         // A zero denominator gives a zero gain.
         k = (den == 0) ? 0 : (pp << 16) / den;
         if (k > ONE_Q16) k = ONE_Q16;
         np = ((ONE_Q16 - k) * pp + HALF_Q16) >> 16;
         if (np > COV_MAX) np = COV_MAX;
         cov = np[COV_W-1:0];
         return longint'(k);
      endfunction

      function void note_sample(accel_vec a);
         longint    ka, kv, kp, prev, raw;
         motion_est e;
         ka = gain_step(acc_cov, noise[CSR_ACC_PROC], noise[CSR_ACC_MEAS]);
         kv = gain_step(vel_cov, noise[CSR_VEL_PROC], noise[CSR_VEL_MEAS]);
         kp = gain_step(pos_cov, noise[CSR_POS_PROC], noise[CSR_POS_MEAS]);
         for (int i = 0; i < NAXES; i++) begin
            prev = acc_state[i];
            acc_state[i] = clamp_est(prev + round_q16(ka * (longint'(a.axis[i]) - prev)));
            // Velocity and position integrate the new estimate of the stage before.
            raw = longint'(vel_state[i]) + longint'(acc_state[i]);
            vel_state[i] = clamp_est(round_q16(kv * raw));
            raw = longint'(pos_state[i]) + longint'(vel_state[i]);
            pos_state[i] = clamp_est(round_q16(kp * raw));
            e.acc[i] = acc_state[i];
            e.vel[i] = vel_state[i];
            e.pos[i] = pos_state[i];
         end
         pending_estimates.push_back(e);
         samples_taken++;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task compare_field(string stage, int i, est_t got, est_t want);
         string letters = "xyz";
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s_%c: got %0d, expected %0d",
                                      results_checked, stage, letters[i], got, want));
         end
      endtask

      task check_result(motion_est got);
         motion_est want;
         if (pending_estimates.size() == 0) begin
            report_mismatch("result transfer with no sample outstanding");
            return;
         end
         want = pending_estimates.pop_front();
         results_checked++;
         for (int i = 0; i < NAXES; i++) begin
            compare_field("acc_est", i, got.acc[i], want.acc[i]);
            compare_field("vel_est", i, got.vel[i], want.vel[i]);
            compare_field("pos_est", i, got.pos[i], want.pos[i]);
         end
      endtask

      task check_drained();
         if (pending_estimates.size() != 0) begin
            report_mismatch($sformatf("%0d samples never produced a result",
                                      pending_estimates.size()));
         end
      endtask

      function int pending();
         return pending_estimates.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idling = 1'b1;
   int   hold_left = 0;
   int   noise_settings = 0;
   int   walk[NAXES];

   motion_checker estimate_book = new();

   ckm_csr_if csr_if ();
   ckm_req_if req_if ();
   ckm_rsp_if rsp_if ();

   cascaded_scalar_kalman_motion_top dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_if),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Result side: random stalls, plus a long hold-off when one is requested.
   initial begin : result_receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= !(idling && $urandom_range(99) < 6);
         end
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      motion_est got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.acc[0] = rsp_if.acc_est_x;
         got.acc[1] = rsp_if.acc_est_y;
         got.acc[2] = rsp_if.acc_est_z;
         got.vel[0] = rsp_if.vel_est_x;
         got.vel[1] = rsp_if.vel_est_y;
         got.vel[2] = rsp_if.vel_est_z;
         got.pos[0] = rsp_if.pos_est_x;
         got.pos[1] = rsp_if.pos_est_y;
         got.pos[2] = rsp_if.pos_est_z;
         estimate_book.check_result(got);
      end
   end

   // Offers one sample, after an optional gap, and waits for its transfer.
   task automatic send_accel(accel_vec a, int gap);
      @(negedge clock);
      while (gap > 0 || (idling && $urandom_range(99) < 6)) begin
         req_if.valid <= 1'b0;
         if (gap > 0) gap--;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.meas_x <= a.axis[0];
      req_if.meas_y <= a.axis[1];
      req_if.meas_z <= a.axis[2];
      do @(posedge clock); while (req_if.ready !== 1'b1);
      estimate_book.note_sample(a);
   endtask

   task automatic send_xyz(est_t x, est_t y, est_t z);
      accel_vec a;
      a.axis[0] = x;
      a.axis[1] = y;
      a.axis[2] = z;
      send_accel(a, 0);
   endtask

   // Stops offering samples and waits until every prediction has been matched.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (estimate_book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_noise(logic [CSR_IDX_W-1:0] idx, logic [NOISE_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      estimate_book.write_register(idx, value);
   endtask

   // Register writes happen only once the block has gone idle.
   task automatic apply_noise(noise_set vals);
      wait_drained();
      for (int r = CSR_ACC_PROC; r <= CSR_POS_MEAS; r++) begin
         write_noise(CSR_IDX_W'(r), vals[r]);
      end
      write_noise(CSR_SPARE_LO, NOISE_W'($urandom));
      write_noise(CSR_SPARE_HI, NOISE_W'($urandom));
      @(negedge clock);
      csr_if.valid <= 1'b0;
      noise_settings++;
   endtask

   function automatic logic [NOISE_W-1:0] random_noise();
      case ($urandom_range(3))
         0: return '0;
         1: return NOISE_TOP;
         default: return NOISE_W'($urandom);
      endcase
   endfunction

   // Mix of full-range values, smooth motion, small values and extremes per axis.
   function automatic accel_vec random_accel();
      accel_vec a;
      int       roll;
      for (int i = 0; i < NAXES; i++) begin
         roll = $urandom_range(99);
         if (roll < 35) begin
            a.axis[i] = est_t'($urandom);
         end else if (roll < 65) begin
            walk[i] += int'($urandom_range(4096)) - 2048;
            if (walk[i] > int'(EST_MAX) || walk[i] < int'(EST_MIN)) walk[i] = 0;
            a.axis[i] = est_t'(walk[i]);
         end else if (roll < 85) begin
            a.axis[i] = est_t'(int'($urandom_range(131072)) - 65536);
         end else begin
            case ($urandom_range(4))
               0: a.axis[i] = EST_MAX;
               1: a.axis[i] = EST_MIN;
               2: a.axis[i] = '0;
               3: a.axis[i] = -1;
               default: a.axis[i] = 1;
            endcase
         end
      end
      return a;
   endfunction

   initial begin : stimulus
      noise_set cfg;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.meas_x = '0;
      req_if.meas_y = '0;
      req_if.meas_z = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = '0;
      csr_if.data   = '0;
      foreach (walk[i]) walk[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Field extremes and bit patterns under the reset settings.
      send_xyz('0, '0, '0);
      send_xyz(EST_MAX, EST_MAX, EST_MAX);
      send_xyz(EST_MIN, EST_MIN, EST_MIN);
      send_xyz(EST_MAX, EST_MIN, '0);
      send_xyz(-1, 1, EST_MAX);
      send_xyz(est_t'(24'h555555), est_t'(24'hAAAAAA), EST_MIN);

      // All noise zero: the first transfer clears the covariances, after which the
      // gain denominator is zero and every gain is zero.
      cfg = '{default: '0};
      apply_noise(cfg);
      send_xyz(EST_MAX, EST_MIN, est_t'(24'h123456));
      send_xyz(1, -1, '0);
      send_xyz(EST_MIN, EST_MAX, -1);

      // Unity gain: the estimates integrate until they saturate both ways.
      cfg[CSR_ACC_PROC] = NOISE_TOP;
      cfg[CSR_ACC_MEAS] = '0;
      cfg[CSR_VEL_PROC] = NOISE_TOP;
      cfg[CSR_VEL_MEAS] = '0;
      cfg[CSR_POS_PROC] = NOISE_TOP;
      cfg[CSR_POS_MEAS] = '0;
      apply_noise(cfg);
      repeat (4) send_xyz(EST_MAX, EST_MAX, EST_MIN);
      repeat (5) send_xyz(EST_MIN, EST_MIN, EST_MAX);

      // Random phases, each under its own noise setting.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               cfg[CSR_ACC_PROC] = ACC_PROC_RST;
               cfg[CSR_ACC_MEAS] = ACC_MEAS_RST;
               cfg[CSR_VEL_PROC] = VEL_PROC_RST;
               cfg[CSR_VEL_MEAS] = VEL_MEAS_RST;
               cfg[CSR_POS_PROC] = POS_PROC_RST;
               cfg[CSR_POS_MEAS] = POS_MEAS_RST;
            end
            1: cfg = '{default: NOISE_TOP};
            2: cfg = '{default: '0};
            3: begin
               cfg[CSR_ACC_PROC] = NOISE_TOP;
               cfg[CSR_ACC_MEAS] = '0;
               cfg[CSR_VEL_PROC] = NOISE_TOP;
               cfg[CSR_VEL_MEAS] = '0;
               cfg[CSR_POS_PROC] = NOISE_TOP;
               cfg[CSR_POS_MEAS] = '0;
            end
            4: begin
               cfg[CSR_ACC_PROC] = '0;
               cfg[CSR_ACC_MEAS] = NOISE_TOP;
               cfg[CSR_VEL_PROC] = '0;
               cfg[CSR_VEL_MEAS] = NOISE_TOP;
               cfg[CSR_POS_PROC] = '0;
               cfg[CSR_POS_MEAS] = NOISE_TOP;
            end
            default: begin
               foreach (cfg[r]) cfg[r] = random_noise();
            end
         endcase
         apply_noise(cfg);
         // One phase runs with neither side idling.
         idling = (p != 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // The result side holds off long enough for the block to stall its input.
            if (p == 5 && n == 10) hold_left = HOLD_CYCLES;
            send_accel(random_accel(), ($urandom_range(99) < 3) ? $urandom_range(1, 100) : 0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      estimate_book.check_drained();
      $display("Run covered %0d samples and %0d checked results over %0d noise settings,",
               estimate_book.samples_taken, estimate_book.results_checked, noise_settings);
      $display("with zero and unity gains, estimate saturation and a long result stall.");
      if (estimate_book.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
